@@ rtl/core/bfvd_pkg.sv @@
// types and constants for the frame verify deframer
// depends on nothing; imported by bcc_frame_verify_deframer_core
`default_nettype none

package bfvd_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned COUNT_W  = 10;
   localparam int unsigned MINLEN_W = 9;
   localparam int unsigned CODE_W   = 3;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 9;
   localparam int unsigned RSP_DATA_W = 16;

   localparam logic [COUNT_W-1:0]  COUNT_MAX      = 10'd1023;
   localparam logic [BYTE_W-1:0]   START_RESET    = 8'd170;
   localparam logic [BYTE_W-1:0]   END_RESET      = 8'd187;
   localparam logic [MINLEN_W-1:0] MIN_LEN_RESET  = 9'd6;
   localparam logic [COUNT_W-1:0]  LEN_OVERHEAD   = 10'd5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_MARKER = 2'd0,
      CSR_END_MARKER   = 2'd1,
      CSR_MIN_LEN      = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   typedef enum logic [CODE_W-1:0] {
      ERR_NONE      = 3'd0,
      ERR_SHORT     = 3'd1,
      ERR_NO_START  = 3'd2,
      ERR_NO_END    = 3'd3,
      ERR_BCC       = 3'd4,
      ERR_LEN_ZERO  = 3'd5,
      ERR_SIZE      = 3'd6,
      ERR_RESERVED  = 3'd7
   } err_code_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_VERDICT = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [BYTE_W-1:0]   payload_byte;
      logic                frame_ok;
      err_code_type        error_code;
      logic                run_last;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/core/bcc_frame_verify_deframer_core.sv @@
// frame verify deframer: strips start, bcc and end bytes, emits a verdict per frame
// depends on bfvd_pkg; results leave through a four-entry result queue
// order: the results of a request are written to the result queue when it is accepted, payload
//   byte first; a verdict behind a payload byte of the same request follows it on rsp
// throughput: one request per cycle while the queue holds at most two results
// reset: clears frame state and the queue, and loads the register reset values
`default_nettype none

module bcc_frame_verify_deframer_core #(
   parameter int unsigned MAX_FRAME_LEN = 260
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [bfvd_pkg::BYTE_W-1:0]       req_tdata,   // rx_byte
   input  wire logic                              req_tlast,   // frame_end
   // result channel
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [bfvd_pkg::RSP_DATA_W-1:0]        rsp_tdata,   // payload_byte, frame_ok, error_code
   output logic                                   rsp_tuser,   // kind
   output logic                                   rsp_tlast,   // run_last
   // register write port
   input  wire logic                              csr_we,
   input  wire logic [bfvd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bfvd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bfvd_pkg::*;

   localparam logic [COUNT_W-1:0] MAX_LEN = COUNT_W'(MAX_FRAME_LEN);
   localparam int unsigned Q_DEPTH = 4;
   localparam int unsigned Q_PTR_W = 2;
   localparam int unsigned Q_CNT_W = 3;

   logic [BYTE_W-1:0]   start_marker_ff;
   logic [BYTE_W-1:0]   end_marker_ff;
   logic [MINLEN_W-1:0] min_len_ff;

   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0]   first_ff, first_in;
   logic [BYTE_W-1:0]   older_ff;
   logic [BYTE_W-1:0]   newer_ff;
   logic [BYTE_W-1:0]   xor_ff, xor_in;
   logic [BYTE_W-1:0]   len_ff, len_in;

   result_type          queue_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]  wptr_ff, rptr_ff;
   logic [Q_CNT_W-1:0]  qcount_ff;

   logic                accept, pop, emit, fend;
   logic [BYTE_W-1:0]   rx_byte;
   err_code_type        code;
   result_type          pay_item, verdict_item, head;
   logic [Q_PTR_W-1:0]  verdict_ptr;
   logic [Q_CNT_W-1:0]  push_n;

   assign rx_byte    = req_tdata;
   assign fend       = req_tlast;
   assign req_tready = (qcount_ff <= Q_CNT_W'(Q_DEPTH - 2));
   assign accept     = req_tvalid & req_tready;
   assign rsp_tvalid = (qcount_ff != '0);
   assign pop        = rsp_tvalid & rsp_tready;

   assign head      = queue_ff[rptr_ff];
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.run_last;
   assign rsp_tdata = {4'b0000, head.error_code, head.frame_ok, head.payload_byte};

   always_comb begin
      emit     = (count_ff >= COUNT_W'(3));
      xor_in   = emit ? (xor_ff ^ older_ff) : xor_ff;
      first_in = (count_ff == '0) ? rx_byte : first_ff;
      len_in   = (count_ff == COUNT_W'(2)) ? rx_byte : len_ff;
      count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_W'(1);

      if (count_in < {1'b0, min_len_ff}) begin
         code = ERR_SHORT;
      end else if (first_in != start_marker_ff) begin
         code = ERR_NO_START;
      end else if (rx_byte != end_marker_ff) begin
         code = ERR_NO_END;
      end else if (newer_ff != xor_in) begin
         code = ERR_BCC;
      end else if (len_in == '0) begin
         code = ERR_LEN_ZERO;
      end else if ((count_in > MAX_LEN) ||
                   (count_in != ({2'b00, len_in} + LEN_OVERHEAD))) begin
         code = ERR_SIZE;
      end else begin
         code = ERR_NONE;
      end

      pay_item.kind         = KIND_PAYLOAD;
      pay_item.payload_byte = older_ff;
      pay_item.frame_ok     = 1'b0;
      pay_item.error_code   = ERR_NONE;
      pay_item.run_last     = ~fend;

      verdict_item.kind         = KIND_VERDICT;
      verdict_item.payload_byte = '0;
      verdict_item.frame_ok     = (code == ERR_NONE);
      verdict_item.error_code   = code;
      verdict_item.run_last     = 1'b1;

      verdict_ptr = wptr_ff + Q_PTR_W'(emit);
      push_n      = accept ? (Q_CNT_W'(emit) + Q_CNT_W'(fend)) : '0;
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         queue_ff[wptr_ff] <= pay_item;
      end
      if (accept && fend) begin
         queue_ff[verdict_ptr] <= verdict_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff   <= '0;
         rptr_ff   <= '0;
         qcount_ff <= '0;
      end else begin
         wptr_ff   <= wptr_ff + push_n[Q_PTR_W-1:0];
         rptr_ff   <= rptr_ff + Q_PTR_W'(pop);
         qcount_ff <= qcount_ff + push_n - Q_CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_RESET;
         end_marker_ff   <= END_RESET;
         min_len_ff      <= MIN_LEN_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_MARKER: start_marker_ff <= csr_wdata[BYTE_W-1:0];
            CSR_END_MARKER:   end_marker_ff   <= csr_wdata[BYTE_W-1:0];
            CSR_MIN_LEN:      min_len_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         first_ff <= '0;
         older_ff <= '0;
         newer_ff <= '0;
         xor_ff   <= '0;
         len_ff   <= '0;
      end else if (accept) begin
         if (fend) begin
            count_ff <= '0;
            first_ff <= '0;
            older_ff <= '0;
            newer_ff <= '0;
            xor_ff   <= '0;
            len_ff   <= '0;
         end else begin
            count_ff <= count_in;
            first_ff <= first_in;
            older_ff <= newer_ff;
            newer_ff <= rx_byte;
            xor_ff   <= xor_in;
            len_ff   <= len_in;
         end
      end
   end

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// self-checking testbench for bcc_frame_verify_deframer_core: directed frames, register
// extremes, oversize frames, back-pressure and random traffic, scored by an in-bench predictor
// depends on bfvd_pkg and the core; needs no files or arguments
`timescale 1ns / 1ps

module tb_top;
   import bfvd_pkg::*;

   localparam int unsigned MAX_LEN     = 260;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned QUIET_WAIT  = 8;
   localparam int unsigned EXP_DEPTH   = 64;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata = '0;     // rx_byte
   logic                  req_tlast = 1'b0;   // frame_end
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // payload_byte, frame_ok, error_code, zero fill
   logic                  rsp_tuser;          // kind
   logic                  rsp_tlast;          // run_last
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bcc_frame_verify_deframer_core #(.MAX_FRAME_LEN(MAX_LEN)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor copy of registers and frame state
   logic [7:0]  cfg_start;
   logic [7:0]  cfg_end;
   logic [8:0]  cfg_min_len;
   logic [9:0]  rx_count;
   logic [7:0]  lead_byte;
   logic [7:0]  lag2_byte;
   logic [7:0]  lag1_byte;
   logic [7:0]  bcc_run;
   logic [7:0]  len_byte;

   result_type  exp_fifo [EXP_DEPTH];
   int unsigned exp_wr = 0;
   int unsigned exp_rd = 0;
   logic [7:0]  frame_buf[];
   int          error_count = 0;
   int          sent_items = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned hold_epoch = 0;

   task automatic report_mismatch(input string what);
      if (error_count < 40) $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   task automatic add_expected(input result_type r);
      exp_fifo[exp_wr % EXP_DEPTH] = r;
      exp_wr++;
   endtask

   task automatic clear_frame();
      rx_count  = '0;
      lead_byte = '0;
      lag2_byte = '0;
      lag1_byte = '0;
      bcc_run   = '0;
      len_byte  = '0;
   endtask

   task automatic deframe_step(input logic [7:0] b, input logic fend);
      logic [9:0]   idx;
      logic [7:0]   bcc_byte;
      logic [9:0]   size;
      err_code_type code;
      result_type   r;
      idx = rx_count;
      if (idx >= 10'd3) begin
         bcc_run = bcc_run ^ lag2_byte;
         r.kind = KIND_PAYLOAD;
         r.payload_byte = lag2_byte;
         r.frame_ok = 1'b0;
         r.error_code = ERR_NONE;
         r.run_last = ~fend;
         add_expected(r);
      end
      if (idx == 10'd0) lead_byte = b;
      if (idx == 10'd2) len_byte = b;
      bcc_byte  = lag1_byte;
      lag2_byte = lag1_byte;
      lag1_byte = b;
      if (rx_count != 10'd1023) rx_count = rx_count + 10'd1;
      if (fend) begin
         size = rx_count;
         if (size < {1'b0, cfg_min_len}) code = ERR_SHORT;
         else if (lead_byte != cfg_start) code = ERR_NO_START;
         else if (b != cfg_end) code = ERR_NO_END;
         else if (bcc_byte != bcc_run) code = ERR_BCC;
         else if (len_byte == 8'd0) code = ERR_LEN_ZERO;
         else if (size > 10'(MAX_LEN) || size != {2'b00, len_byte} + 10'd5) code = ERR_SIZE;
         else code = ERR_NONE;
         r.kind = KIND_VERDICT;
         r.payload_byte = 8'd0;
         r.frame_ok = (code == ERR_NONE);
         r.error_code = code;
         r.run_last = 1'b1;
         add_expected(r);
         clear_frame();
      end
   endtask

   // results are checked before this edge's request is predicted
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         cfg_start   = 8'd170;
         cfg_end     = 8'd187;
         cfg_min_len = 9'd6;
         clear_frame();
         exp_wr = 0;
         exp_rd = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (exp_wr == exp_rd) begin
               report_mismatch($sformatf("unexpected result tuser %0d tdata %04x",
                  rsp_tuser, rsp_tdata));
            end else begin
               want = exp_fifo[exp_rd % EXP_DEPTH];
               exp_rd++;
               if (rsp_tuser !== want.kind || rsp_tdata[7:0] !== want.payload_byte ||
                   rsp_tdata[8] !== want.frame_ok || rsp_tdata[11:9] !== want.error_code ||
                   rsp_tlast !== want.run_last)
                  report_mismatch($sformatf(
                     "kind %0d/%0d byte %02x/%02x ok %0d/%0d code %0d/%0d last %0d/%0d",
                     rsp_tuser, want.kind, rsp_tdata[7:0], want.payload_byte,
                     rsp_tdata[8], want.frame_ok, rsp_tdata[11:9], want.error_code,
                     rsp_tlast, want.run_last));
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_START_MARKER: cfg_start = csr_wdata[7:0];
               CSR_END_MARKER:   cfg_end = csr_wdata[7:0];
               CSR_MIN_LEN:      cfg_min_len = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) deframe_step(req_tdata, req_tlast);
      end
   end

   // receiver: random stalls plus long hold-offs on request
   int unsigned seen_epoch = 0;
   int unsigned hold_left = 0;
   always @(posedge clock) begin
      if (hold_epoch != seen_epoch) begin
         seen_epoch = hold_epoch;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_items++;
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_buf.size(); i++)
         send_byte(frame_buf[i], i == frame_buf.size() - 1);
   endtask

   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      @(posedge clock);
      while (exp_wr != exp_rd) @(posedge clock);
      repeat (QUIET_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [8:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic fix_bcc();
      logic [7:0] x;
      x = 8'd0;
      for (int i = 1; i < frame_buf.size() - 2; i++) x = x ^ frame_buf[i];
      frame_buf[frame_buf.size() - 2] = x;
   endtask

   // start, address, length, body bytes, bcc, end
   task automatic make_frame(input int body, input logic [7:0] lenb);
      frame_buf = new[body + 5];
      frame_buf[0] = cfg_start;
      frame_buf[1] = 8'($urandom_range(255));
      frame_buf[2] = lenb;
      for (int i = 0; i < body; i++) frame_buf[3 + i] = 8'($urandom_range(255));
      frame_buf[body + 3] = 8'd0;
      frame_buf[body + 4] = cfg_end;
      fix_bcc();
   endtask

   task automatic random_frame();
      int sel;
      int body;
      int keep;
      sel = $urandom_range(99);
      body = $urandom_range(99);
      if (body < 80) body = $urandom_range(1, 10);
      else if (body < 95) body = $urandom_range(11, 40);
      else body = $urandom_range(41, 80);
      make_frame(body, 8'(body));
      if (sel >= 70) begin
         case ($urandom_range(6))
            0: frame_buf[0] = frame_buf[0] ^ 8'($urandom_range(1, 255));
            1: frame_buf[frame_buf.size() - 1] =
                  frame_buf[frame_buf.size() - 1] ^ 8'($urandom_range(1, 255));
            2: frame_buf[frame_buf.size() - 2] =
                  frame_buf[frame_buf.size() - 2] ^ 8'($urandom_range(1, 255));
            3: begin
               frame_buf[2] = 8'd0;
               fix_bcc();
            end
            4: begin
               frame_buf[2] = frame_buf[2] + 8'($urandom_range(1, 255));
               fix_bcc();
            end
            5: begin
               keep = $urandom_range(1, 5);
               frame_buf = new[keep](frame_buf);
            end
            default: begin
               frame_buf = new[$urandom_range(1, 8)];
               foreach (frame_buf[i]) frame_buf[i] = 8'($urandom_range(255));
            end
         endcase
      end
      send_frame();
   endtask

   // one frame per verdict code other than the size error, under reset register values
   task automatic test_directed_checks();
      frame_buf = '{8'hAA, 8'hFF, 8'h01, 8'h00, 8'hFE, 8'hBB};
      send_frame();
      frame_buf = '{8'h55};
      send_frame();
      frame_buf = '{8'h00, 8'hFF, 8'h01, 8'h00, 8'hFE, 8'hBB};
      send_frame();
      frame_buf = '{8'hAA, 8'hFF, 8'h01, 8'h00, 8'hFE, 8'h00};
      send_frame();
      frame_buf = '{8'hAA, 8'hFF, 8'h01, 8'h00, 8'h00, 8'hBB};
      send_frame();
      frame_buf = '{8'hAA, 8'h01, 8'h00, 8'h7F, 8'h7E, 8'hBB};
      send_frame();
      wait_quiet();
   endtask

   // tiny frames with a zero minimum, the unused index, full-width minimum
   task automatic test_marker_and_size_extremes();
      write_csr(CSR_MIN_LEN, 9'd0);
      write_csr(CSR_START_MARKER, 9'h000);
      write_csr(CSR_END_MARKER, 9'h0FF);
      frame_buf = '{8'hFF};
      send_frame();
      frame_buf = '{8'h00};
      send_frame();
      frame_buf = '{8'h00, 8'hFF};
      send_frame();
      frame_buf = '{8'h00, 8'h5A, 8'hFF};
      send_frame();
      frame_buf = '{8'h00, 8'h00, 8'hFF};
      send_frame();
      wait_quiet();
      write_csr(CSR_UNUSED, 9'h1FF);
      write_csr(CSR_END_MARKER, 9'h000);
      frame_buf = '{8'h00};
      send_frame();
      make_frame(3, 8'd3);
      send_frame();
      wait_quiet();
      write_csr(CSR_START_MARKER, 9'h0FF);
      write_csr(CSR_MIN_LEN, 9'h1FF);
      make_frame(3, 8'd3);
      send_frame();
      wait_quiet();
   endtask

   // largest valid frame, then an oversize frame that saturates the byte counter
   task automatic test_length_limits();
      write_csr(CSR_START_MARKER, 9'd170);
      write_csr(CSR_END_MARKER, 9'd187);
      write_csr(CSR_MIN_LEN, 9'd260);
      make_frame(255, 8'd255);
      send_frame();
      wait_quiet();
      write_csr(CSR_MIN_LEN, 9'd511);
      make_frame(1020, 8'd255);
      send_frame();
      wait_quiet();
      write_csr(CSR_MIN_LEN, 9'd6);
   endtask

   // receiver holds off while requests keep coming, then sender waits for the drain
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      @(negedge clock);
      hold_epoch++;
      @(posedge clock);
      make_frame(20, 8'd20);
      send_frame();
      make_frame(2, 8'd2);
      send_frame();
      wait_quiet();
   endtask

   task automatic test_random_traffic(input int unsigned idle, input int unsigned stall,
                                      input int count);
      int goal;
      send_idle_pct = idle;
      rsp_stall_pct = stall;
      write_csr(CSR_START_MARKER, 9'($urandom_range(255)));
      write_csr(CSR_END_MARKER, 9'($urandom_range(255)));
      write_csr(CSR_MIN_LEN, 9'($urandom_range(3, 12)));
      goal = sent_items + count;
      while (sent_items < goal) random_frame();
      wait_quiet();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_checks();
      test_marker_and_size_extremes();
      test_length_limits();
      test_backpressure();
      test_random_traffic(0, 0, 50);
      test_random_traffic(50, 0, 50);
      test_random_traffic(0, 50, 50);
      test_random_traffic(36, 36, 50);
      if (error_count == 0) begin
         $display("** bcc_frame_verify_deframer_core: PASSED **");
      end else begin
         $display("** bcc_frame_verify_deframer_core: FAILED **");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("timeout with %0d results pending", exp_wr - exp_rd);
      $display("** bcc_frame_verify_deframer_core: FAILED **");
      $finish;
   end

endmodule
